/* hw/rtl/firq_pkg.sv */
// ----------------------------------------------------------------------------
// firq_pkg
// types and constants shared by the fixed-point fir filter
// ----------------------------------------------------------------------------
package firq_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int ACC_W          = 32;
    localparam int NUM_COEF       = 16;
    localparam int NUM_COEF_WORDS = 4;
    localparam int COEF_WORD_W    = 64;
    localparam int TAP_COUNT_W    = 5;
    localparam int CFG_INDEX_W    = 3;
    localparam int OUT_SHIFT      = 16;

    typedef logic signed [SAMPLE_W-1:0]                     sample_t;
    typedef logic signed [COEF_W-1:0]                       coef_t;
    typedef logic [ACC_W-1:0]                               acc_t;
    typedef logic [TAP_COUNT_W-1:0]                         tap_count_t;
    typedef logic [CFG_INDEX_W-1:0]                         cfg_index_t;
    typedef logic [COEF_WORD_W-1:0]                         coef_word_t;
    typedef logic [NUM_COEF_WORDS-1:0][COEF_WORD_W-1:0]     coef_bank_t;

    localparam acc_t       ROUND_ADD       = 32'h0000_8000;
    localparam tap_count_t TAP_COUNT_RESET = 5'd1;

    localparam cfg_index_t REG_TAP_COUNT = 3'd0;
    localparam cfg_index_t REG_COEF_0    = 3'd1;
    localparam cfg_index_t REG_COEF_1    = 3'd2;
    localparam cfg_index_t REG_COEF_2    = 3'd3;
    localparam cfg_index_t REG_COEF_3    = 3'd4;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    typedef struct packed {
        logic en;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic coef_t coef_pick(coef_bank_t bank, logic [3:0] k);
        coef_word_t word;
        word = bank[k[3:2]];
        return word[k[1:0]*COEF_W +: COEF_W];
    endfunction

endpackage

/* hw/rtl/firq_if.sv */
// ----------------------------------------------------------------------------
// firq channel interfaces
// valid/ready channels for samples, filtered results and register writes
// ----------------------------------------------------------------------------
interface firq_sample_if;
    logic              valid;
    logic              ready;
    firq_pkg::sample_t sample_in;
    logic              row_end;

    modport source (output valid, output sample_in, output row_end, input ready);
    modport sink   (input valid, input sample_in, input row_end, output ready);
endinterface

interface firq_result_if;
    logic              valid;
    logic              ready;
    firq_pkg::sample_t filtered;
    logic              row_end_out;

    modport source (output valid, output filtered, output row_end_out, input ready);
    modport sink   (input valid, input filtered, input row_end_out, output ready);
endinterface

interface firq_cfg_if;
    logic                 valid;
    logic                 ready;
    firq_pkg::cfg_index_t index;
    firq_pkg::coef_word_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/firq_cell.sv */
// ----------------------------------------------------------------------------
// firq_cell
// one delay line cell: holds a sample, passes it on, registers its product
// ----------------------------------------------------------------------------
module firq_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  firq_pkg::cell_ctrl_t ctrl,
    input  firq_pkg::sample_t    sample_prev,
    input  firq_pkg::coef_t      coef,
    output firq_pkg::sample_t    sample,
    output firq_pkg::acc_t       product
);
    import firq_pkg::*;

    sample_t sample_reg;
    acc_t    product_reg;
    logic signed [ACC_W-1:0] product_next;

    assign product_next = ACC_W'(coef) * ACC_W'(sample_prev);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            sample_reg <= ctrl.clear ? '0 : sample_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            product_reg <= acc_t'(product_next);
        end
    end

    assign sample  = sample_reg;
    assign product = product_reg;

endmodule

/* hw/rtl/firq_adder_tree.sv */
// ----------------------------------------------------------------------------
// firq_adder_tree
// binary adder tree over the cell products, with a register at each level
// ----------------------------------------------------------------------------
module firq_adder_tree #(
    parameter int N = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [N-1:0][firq_pkg::ACC_W-1:0] leaves,
    input  firq_pkg::tag_t                  tag_in,
    output firq_pkg::acc_t                  sum,
    output firq_pkg::tag_t                  tag_out
);
    import firq_pkg::*;

    localparam int L = $clog2(N);
    localparam int P = 1 << L;

    generate
        if (L == 0)
        begin : g_flat
            assign sum     = leaves[0];
            assign tag_out = tag_in;
        end
        else
        begin : g_tree
            acc_t leaf     [0:P-1];
            acc_t node_reg [1:P-1];
            tag_t tag_reg  [1:L];

            for (genvar i = 0; i < P; i++)
            begin : g_leaf
                if (i < N)
                begin : g_used
                    assign leaf[i] = leaves[i];
                end
                else
                begin : g_pad
                    assign leaf[i] = '0;
                end
            end

            for (genvar i = 1; i < P; i++)
            begin : g_node
                acc_t left;
                acc_t right;
                if (2 * i >= P)
                begin : g_from_leaf
                    assign left  = leaf[2*i-P];
                    assign right = leaf[2*i+1-P];
                end
                else
                begin : g_from_node
                    assign left  = node_reg[2*i];
                    assign right = node_reg[2*i+1];
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        node_reg[i] <= left + right;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    for (int l = 1; l <= L; l++)
                    begin
                        tag_reg[l] <= '0;
                    end
                end
                else if (en)
                begin
                    tag_reg[1] <= tag_in;
                    for (int l = 2; l <= L; l++)
                    begin
                        tag_reg[l] <= tag_reg[l-1];
                    end
                end
            end

            assign sum     = node_reg[1];
            assign tag_out = tag_reg[L];
        end
    endgenerate

endmodule

/* hw/rtl/fir_filter_q16_round.sv */
// ----------------------------------------------------------------------------
// fir_filter_q16_round
// one product register in the cell row, then one register per level of
// the adder tree; throughput one request per cycle; the whole pipeline
// holds while the result is not taken; reset clears the delay line,
// tap_count 1, coefs 0
// ----------------------------------------------------------------------------
module fir_filter_q16_round #(
    parameter int MAX_TAPS = 16
) (
    input  logic clk,
    input  logic rst_n,
    firq_sample_if.sink   samples,
    firq_result_if.source results,
    firq_cfg_if.sink      cfg
);
    import firq_pkg::*;

    localparam int UW = $clog2(MAX_TAPS + 1);

    tap_count_t tap_count_reg;
    coef_bank_t coef_reg;
    logic [UW-1:0] used;

    logic       en;
    logic       accept;
    cell_ctrl_t cell_ctrl;
    tag_t       cell_tag_reg;
    tag_t       tree_tag;
    acc_t       root;
    acc_t       rounded;

    sample_t                       line  [0:MAX_TAPS-1];
    logic [MAX_TAPS-1:0][ACC_W-1:0] prods;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
            coef_reg      <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TAP_COUNT: tap_count_reg <= cfg.data[TAP_COUNT_W-1:0];
                REG_COEF_0:    coef_reg[0]   <= cfg.data;
                REG_COEF_1:    coef_reg[1]   <= cfg.data;
                REG_COEF_2:    coef_reg[2]   <= cfg.data;
                REG_COEF_3:    coef_reg[3]   <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if ({3'b000, tap_count_reg} > 8'(MAX_TAPS))
        begin
            used = UW'(MAX_TAPS);
        end
        else
        begin
            used = UW'(tap_count_reg);
        end
    end

    // handshake
    assign en             = !results.valid || results.ready;
    assign samples.ready  = en;
    assign accept         = samples.valid && en;
    assign cell_ctrl.en    = en;
    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = samples.row_end;

    // cell row, cell j holds the sample j places back
    generate
        for (genvar j = 0; j < MAX_TAPS; j++)
        begin : g_cell
            logic [7:0] back_k;
            logic       active;
            coef_t      coef;
            sample_t    prev;

            assign back_k = 8'(used) - 8'(j + 1);
            assign active = 8'(used) > 8'(j);
            assign coef   = (active && back_k < 8'(NUM_COEF)) ?
                            coef_pick(coef_reg, back_k[3:0]) : '0;

            if (j == 0)
            begin : g_head
                assign prev = samples.sample_in;
            end
            else
            begin : g_body
                assign prev = line[j-1];
            end

            firq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .sample_prev (prev),
                .coef        (coef),
                .sample      (line[j]),
                .product     (prods[j])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_tag_reg <= '0;
        end
        else if (en)
        begin
            cell_tag_reg.valid <= accept;
            cell_tag_reg.last  <= samples.row_end;
        end
    end

    firq_adder_tree #(
        .N (MAX_TAPS)
    ) u_tree (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .leaves  (prods),
        .tag_in  (cell_tag_reg),
        .sum     (root),
        .tag_out (tree_tag)
    );

    // round and scale
    assign rounded             = root + ROUND_ADD;
    assign results.valid       = tree_tag.valid;
    assign results.row_end_out = tree_tag.last;
    assign results.filtered    = rounded[OUT_SHIFT +: SAMPLE_W];

    a_row_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.row_end) |=> (line[0] == '0))
        else $error("delay line not cleared after row end");

    a_sample_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !samples.row_end) |=> (line[0] == $past(samples.sample_in)))
        else $error("accepted sample missing from delay line head");

    a_used_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (tap_count_reg != '0) |-> (used != '0))
        else $error("taps in use lost for nonzero tap count");

endmodule

/* test/tb_fir_filter_q16_round.sv */
// ----------------------------------------------------------------------------
// tb_fir_filter_q16_round
// Streams signed samples through the fixed-point fir filter and compares each
// filtered result against an in-bench prediction of the delay line, the
// rounded q16 sum and the row-end clear. Register settings change only while
// the filter is drained: reset values, several tap counts (zero, full,
// saturating), extreme coefficients, and writes to unused indexes. Both sides
// stall in random bursts except in the last phase.
// ----------------------------------------------------------------------------
module tb_fir_filter_q16_round;
    import firq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TAPS        = 16;
    localparam int LATENCY         = 1 + $clog2(MAX_TAPS);
    localparam int RAND_PHASES     = 14;
    localparam int ITEMS_PER_PHASE = 110;

    typedef struct {
        sample_t sample;
        logic    last;
    } sample_req_t;

    typedef struct {
        sample_t filtered;
        logic    row_end_out;
    } filter_result_t;

    logic clk;
    logic rst_n;

    firq_sample_if sample_bus ();
    firq_result_if result_bus ();
    firq_cfg_if    cfg_bus ();

    fir_filter_q16_round #(
        .MAX_TAPS (MAX_TAPS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .results (result_bus),
        .cfg     (cfg_bus)
    );

    // filter settings and window as the block should hold them
    tap_count_t     tap_cnt;
    coef_bank_t     coef_bank;
    sample_t        window [MAX_TAPS];

    sample_req_t    sample_queue [$];
    filter_result_t expected_results [$];
    sample_req_t    next_req;
    filter_result_t got_expected;

    int   items_sent;
    int   results_seen;
    int   error_count;
    int   send_gap;
    int   recv_gap;
    logic send_idle;
    logic recv_idle;

    always #5 clk = ~clk;

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // shift the sample in, form the rounded sum, clear on row end
    task automatic filter_sample(sample_t s, logic last);
        int                 used;
        acc_t               acc;
        logic signed [31:0] prod;
        coef_word_t         word;
        coef_t              c;
        filter_result_t     r;
        for (int i = MAX_TAPS - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = s;
        used = (tap_cnt > MAX_TAPS) ? MAX_TAPS : int'(tap_cnt);
        acc = '0;
        for (int k = 0; k < used; k++)
        begin
            if (k < NUM_COEF)
            begin
                word = coef_bank[k / 4];
                c = word[COEF_W * (k % 4) +: COEF_W];
            end
            else
                c = '0;
            prod = 32'(c) * 32'(window[used - 1 - k]);
            acc = acc + prod;
        end
        acc = acc + ROUND_ADD;
        r.filtered = acc[ACC_W-1:OUT_SHIFT];
        r.row_end_out = last;
        expected_results.push_back(r);
        if (last)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
                window[i] = '0;
        end
    endtask

    task automatic write_reg(cfg_index_t idx, coef_word_t val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_TAP_COUNT: tap_cnt = val[TAP_COUNT_W-1:0];
            REG_COEF_0:    coef_bank[0] = val;
            REG_COEF_1:    coef_bank[1] = val;
            REG_COEF_2:    coef_bank[2] = val;
            REG_COEF_3:    coef_bank[3] = val;
            default:       ;
        endcase
    endtask

    task automatic queue_sample(sample_t s, logic last);
        sample_req_t req;
        req.sample = s;
        req.last = last;
        sample_queue.push_back(req);
        items_sent++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (results_seen < items_sent);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    function automatic coef_t rand_coef();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return coef_t'(16'h8000);
            2:       return '0;
            3:       return coef_t'($urandom_range(0, 64)) - 16'sd32;
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic coef_word_t rand_coef_word();
        return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return sample_t'(16'h8000);
            2:       return '0;
            3:       return sample_t'($urandom_range(0, 512)) - 16'sd256;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // sample driver
    always @(posedge clk)
    begin
        if (sample_bus.valid && sample_bus.ready)
            filter_sample(sample_bus.sample_in, sample_bus.row_end);
        if (rst_n && (!sample_bus.valid || sample_bus.ready))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                sample_bus.valid <= 1'b0;
            end
            else if (send_idle && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(1, 16) - 1;
                sample_bus.valid <= 1'b0;
            end
            else if (sample_queue.size() != 0)
            begin
                next_req = sample_queue.pop_front();
                sample_bus.valid     <= 1'b1;
                sample_bus.sample_in <= next_req.sample;
                sample_bus.row_end   <= next_req.last;
            end
            else
                sample_bus.valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (result_bus.valid && result_bus.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d with no request pending",
                                          result_bus.filtered));
            else
            begin
                got_expected = expected_results.pop_front();
                if (result_bus.filtered !== got_expected.filtered)
                    report_mismatch($sformatf("filtered got %0d expected %0d",
                                              result_bus.filtered,
                                              got_expected.filtered));
                if (result_bus.row_end_out !== got_expected.row_end_out)
                    report_mismatch($sformatf("row_end_out got %b expected %b",
                                              result_bus.row_end_out,
                                              got_expected.row_end_out));
            end
        end
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap--;
                result_bus.ready <= 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 16) - 1;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        tap_count_t tc;
        coef_word_t tc_word;
        int         left;
        int         row_len;
        logic       last_phase;

        clk = 1'b0;
        rst_n = 1'b0;
        sample_bus.valid = 1'b0;
        sample_bus.sample_in = '0;
        sample_bus.row_end = 1'b0;
        result_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_TAP_COUNT;
        cfg_bus.data = '0;
        tap_cnt = TAP_COUNT_RESET;
        coef_bank = '0;
        for (int i = 0; i < MAX_TAPS; i++)
            window[i] = '0;
        items_sent = 0;
        results_seen = 0;
        error_count = 0;
        send_gap = 0;
        recv_gap = 0;
        send_idle = 1'b1;
        recv_idle = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one zero tap
        @(negedge clk);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(sample_t'(16'h8000), 1'b1);
        wait_drained();

        // three taps with extreme coefficients, clear on row end
        write_reg(REG_TAP_COUNT, 64'd3);
        write_reg(REG_COEF_0, {16'h1234, 16'h0001, 16'h8000, 16'h7FFF});
        @(negedge clk);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(sample_t'(16'h8000), 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd1, 1'b0);
        queue_sample(16'sd0, 1'b1);
        queue_sample(16'sd5, 1'b0);
        wait_drained();

        // all sixteen taps at the most negative value, sum wraps
        write_reg(REG_TAP_COUNT, 64'd16);
        write_reg(REG_COEF_0, {4{16'h8000}});
        write_reg(REG_COEF_1, {4{16'h8000}});
        write_reg(REG_COEF_2, {4{16'h8000}});
        write_reg(REG_COEF_3, {4{16'h8000}});
        @(negedge clk);
        for (int i = 0; i < 8; i++)
            queue_sample(sample_t'(16'h8000), i == 7);
        wait_drained();

        // zero taps, then a count that saturates, unused indexes ignored
        write_reg(REG_TAP_COUNT, 64'd0);
        for (int i = int'(REG_COEF_3) + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(cfg_index_t'(i), {$urandom, $urandom});
        @(negedge clk);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(sample_t'(16'h8000), 1'b1);
        wait_drained();
        write_reg(REG_TAP_COUNT, {{(COEF_WORD_W-TAP_COUNT_W){1'b1}}, 5'd31});
        @(negedge clk);
        queue_sample(sample_t'(16'h8000), 1'b0);
        queue_sample(16'sh7FFF, 1'b1);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            last_phase = (p == RAND_PHASES - 1);
            send_idle = !last_phase && ($urandom_range(0, 3) != 0);
            recv_idle = !last_phase && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       tc = '0;
                1:       tc = tap_count_t'(MAX_TAPS);
                2:       tc = tap_count_t'($urandom_range(MAX_TAPS + 1, 31));
                default: tc = tap_count_t'($urandom_range(1, MAX_TAPS));
            endcase
            if (p == 0)
                tc = 5'd1;
            if (p == 1)
                tc = tap_count_t'(MAX_TAPS);
            tc_word = {$urandom, $urandom};
            tc_word[TAP_COUNT_W-1:0] = tc;
            write_reg(REG_TAP_COUNT, tc_word);
            if (p < 2 || $urandom_range(0, 1) == 0)
                write_reg(REG_COEF_0, rand_coef_word());
            if (p < 2 || $urandom_range(0, 1) == 0)
                write_reg(REG_COEF_1, rand_coef_word());
            if (p < 2 || $urandom_range(0, 1) == 0)
                write_reg(REG_COEF_2, rand_coef_word());
            if (p < 2 || $urandom_range(0, 1) == 0)
                write_reg(REG_COEF_3, rand_coef_word());
            if ($urandom_range(0, 4) == 0)
                write_reg(cfg_index_t'($urandom_range(int'(REG_COEF_3) + 1,
                                                      (1 << CFG_INDEX_W) - 1)),
                          {$urandom, $urandom});
            @(negedge clk);
            left = ITEMS_PER_PHASE;
            while (left > 0)
            begin
                row_len = $urandom_range(1, 48);
                for (int j = 0; j < row_len && left > 0; j++)
                begin
                    left--;
                    queue_sample(rand_sample(), j == row_len - 1 || left == 0);
                end
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
